[hdl/tte_pkg.sv]
// Shared types, codes and reset values for the TFTP transfer engine.
// Used by every module of the engine and by its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

  // Default sizes handed down from the top level.
  localparam int TIMER_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Stream widths; the data widths are padded to whole bytes.
  localparam int IN_TUSER_W  = 3;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TUSER_W = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  // Configuration reset values.
  localparam logic [15:0] BLOCK_SIZE_RST  = 16'd512;
  localparam logic [31:0] ACK_WAIT_RST    = 32'd1000;
  localparam logic [31:0] DATA_WAIT_RST   = 32'd5000;
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd3;

  localparam logic [15:0] FIRST_BLOCK = 16'd1;
  localparam logic [15:0] LAST_BLOCK  = 16'hFFFF;
  localparam logic [7:0]  LEAD_OK     = 8'h00;

  typedef enum logic [1:0] {
    CFG_BLOCK_SIZE  = 2'd0,
    CFG_ACK_WAIT    = 2'd1,
    CFG_DATA_WAIT   = 2'd2,
    CFG_RETRY_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_LENGTH = 2'd2
  } req_type_t;

  localparam logic [7:0] OP_RRQ  = 8'd1;
  localparam logic [7:0] OP_WRQ  = 8'd2;
  localparam logic [7:0] OP_DATA = 8'd3;
  localparam logic [7:0] OP_ACK  = 8'd4;

  typedef enum logic [2:0] {
    ACT_ACK   = 3'd0,
    ACT_DATA  = 3'd1,
    ACT_ERROR = 3'd2,
    ACT_STORE = 3'd3,
    ACT_DONE  = 3'd4,
    ACT_ABORT = 3'd5
  } action_t;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NOT_FOUND  = 3'd1;
  localparam logic [2:0] ERR_ILLEGAL_OP = 3'd4;

  // Classified event as it travels from the front end to the executor.
  typedef enum logic [2:0] {
    CMD_RRQ       = 3'd0,
    CMD_WRQ       = 3'd1,
    CMD_NOT_FOUND = 3'd2,
    CMD_ILLEGAL   = 3'd3,
    CMD_DATA      = 3'd4,
    CMD_ACK       = 3'd5,
    CMD_TICK      = 3'd6,
    CMD_LENGTH    = 3'd7
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] blk;
    logic [15:0] len;
  } cmd_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] blk;
    logic [2:0]  err;
    logic [15:0] len;
  } result_t;

endpackage

`default_nettype wire

[hdl/tftp_transfer_engine.sv]
// Top level of the TFTP transfer engine: front end, command queue and executor.
// Depends on tte_pkg, tte_front, tte_queue and tte_back.
// A result passes through the registered command queue and then the result buffer.
// Throughput: one input item per cycle while each causes at most one result and
// out_tready is high; an item's results leave one per cycle, holding the executor.
// Reset (rst_n low, synchronous): queue and result buffer empty, transfer idle,
// configuration registers back at their default values.
`timescale 1ns / 1ps
`default_nettype none

module tftp_transfer_engine #(
  parameter int TIMER_BITS  = tte_pkg::TIMER_BITS_DEF,
  parameter int QUEUE_DEPTH = tte_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration: register index 0 block_size, 1 ack_wait_ticks,
  // 2 data_wait_ticks, 3 retry_limit.
  input  wire logic                            cfg_we,
  input  wire logic [tte_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [tte_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // in_tuser: [1:0] req_type, [2] on_server_port
  input  wire logic [tte_pkg::IN_TUSER_W-1:0]  in_tuser,
  // in_tdata: [7:0] lead_byte, [15:8] opcode_byte, [31:16] block_field,
  //           [47:32] data_length, [48] file_found, [55:49] zero
  input  wire logic [tte_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Result stream; out_tlast marks the final result caused by one input item.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_tuser: [2:0] action
  output logic [tte_pkg::OUT_TUSER_W-1:0]      out_tuser,
  // out_tdata: [15:0] out_block, [18:16] error_code, [34:19] out_length, [39:35] zero
  output logic [tte_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);

  // The front end classifies each item on its own, without looking at the
  // transfer state. Items that no mode reacts to (request type three, peer
  // packets with a bad lead byte or an opcode other than DATA or ACK) are
  // dropped there, so they never occupy the queue.
  logic          q_full;
  logic          q_push;
  tte_pkg::cmd_t q_push_cmd;
  logic          q_pop;
  tte_pkg::cmd_t q_pop_cmd;
  logic          q_valid;

  tte_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  // The queue lets the input side keep accepting items while the executor
  // waits for the output side to take a run of several results.
  tte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_pop_cmd),
    .not_empty (q_valid)
  );

  // The executor applies one command to the transfer state in the cycle it
  // takes it, loads all of that command's results into its buffer, and takes
  // the next command as the final buffered result leaves.
  tte_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (q_pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[hdl/tte_front.sv]
// Front end of the TFTP transfer engine: takes input items and classifies them.
// Items that are ignored in every mode are dropped here. Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_front (
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [tte_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic [tte_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                          q_full,
  output logic                               q_push,
  output tte_pkg::cmd_t                      q_cmd
);

  logic [1:0]  rt;
  logic        srv;
  logic [7:0]  lead;
  logic [7:0]  op;
  logic        found;
  logic        keep;

  assign rt    = in_tuser[1:0];
  assign srv   = in_tuser[2];
  assign lead  = in_tdata[7:0];
  assign op    = in_tdata[15:8];
  assign found = in_tdata[48];

  always_comb begin
    keep       = 1'b1;
    q_cmd.kind = tte_pkg::CMD_TICK;
    q_cmd.blk  = in_tdata[31:16];
    q_cmd.len  = in_tdata[47:32];
    case (rt)
      tte_pkg::REQ_HEADER: begin
        if (srv) begin
          if (lead == tte_pkg::LEAD_OK && (op == tte_pkg::OP_RRQ || op == tte_pkg::OP_WRQ)) begin
            if (!found) begin
              q_cmd.kind = tte_pkg::CMD_NOT_FOUND;
            end else if (op == tte_pkg::OP_RRQ) begin
              q_cmd.kind = tte_pkg::CMD_RRQ;
            end else begin
              q_cmd.kind = tte_pkg::CMD_WRQ;
            end
          end else begin
            q_cmd.kind = tte_pkg::CMD_ILLEGAL;
          end
        end else if (lead == tte_pkg::LEAD_OK && op == tte_pkg::OP_DATA) begin
          q_cmd.kind = tte_pkg::CMD_DATA;
        end else if (lead == tte_pkg::LEAD_OK && op == tte_pkg::OP_ACK) begin
          q_cmd.kind = tte_pkg::CMD_ACK;
        end else begin
          keep = 1'b0;
        end
      end
      tte_pkg::REQ_TICK: begin
        q_cmd.kind = tte_pkg::CMD_TICK;
      end
      tte_pkg::REQ_LENGTH: begin
        q_cmd.kind = tte_pkg::CMD_LENGTH;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && keep;

endmodule

`default_nettype wire

[hdl/tte_queue.sv]
// Short command queue between the front end and the executor.
// Register array with read and write pointers. Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_queue #(
  parameter int DEPTH = tte_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tte_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output tte_pkg::cmd_t      pop_cmd,
  output logic               not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tte_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[hdl/tte_back.sv]
// Executor of the TFTP transfer engine: transfer state, configuration registers
// and a three-entry result buffer that drives the output stream. Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_back #(
  parameter int TIMER_BITS = tte_pkg::TIMER_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [tte_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [tte_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            q_valid,
  input  wire tte_pkg::cmd_t                   q_cmd,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [tte_pkg::OUT_TUSER_W-1:0]      out_tuser,
  output logic [tte_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_WRITE   = 4'b0010,
    MODE_FETCH   = 4'b0100,
    MODE_ACKWAIT = 4'b1000
  } mode_t;

  localparam tte_pkg::result_t RES_NONE = '{action: tte_pkg::ACT_ACK, blk: 16'd0,
                                            err: tte_pkg::ERR_NONE, len: 16'd0};

  // Configuration registers.
  logic [15:0] block_size_r;
  logic [31:0] ack_wait_r;
  logic [31:0] data_wait_r;
  logic [7:0]  retry_limit_r;

  // Transfer state.
  mode_t                 mode_r, mode_nxt;
  logic [15:0]           next_block_r, next_block_nxt;
  logic [7:0]            retry_r, retry_nxt;
  logic [TIMER_BITS-1:0] wait_r, wait_nxt;
  logic                  short_r, short_nxt;

  // Result buffer; entry 0 is the one on the output.
  tte_pkg::result_t res_r [3];
  tte_pkg::result_t res_c [3];
  logic [1:0]       cnt_r;
  logic [1:0]       n_c;

  logic                  fail_abort;
  tte_pkg::result_t      fail_res;
  mode_t                 fail_mode;
  logic [7:0]            fail_retry;
  logic [TIMER_BITS-1:0] wait_inc;
  logic [15:0]           block_inc;

  // A new command is taken when the buffer is empty or its final result leaves now.
  assign q_pop = q_valid && (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_tready));

  always_comb begin
    wait_inc   = (wait_r == '1) ? wait_r : wait_r + 1'b1;
    block_inc  = next_block_r + 16'd1;
    fail_abort = (retry_r >= retry_limit_r);
    if (fail_abort) begin
      fail_res   = '{action: tte_pkg::ACT_ABORT, blk: 16'd0, err: tte_pkg::ERR_NONE, len: 16'd0};
      fail_mode  = MODE_IDLE;
      fail_retry = retry_r;
    end else begin
      fail_res   = '{action: tte_pkg::ACT_DATA, blk: next_block_r, err: tte_pkg::ERR_NONE,
                     len: 16'd0};
      fail_mode  = MODE_FETCH;
      fail_retry = retry_r + 8'd1;
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    next_block_nxt = next_block_r;
    retry_nxt      = retry_r;
    wait_nxt       = wait_r;
    short_nxt      = short_r;
    n_c            = 2'd0;
    res_c[0]       = RES_NONE;
    res_c[1]       = RES_NONE;
    res_c[2]       = RES_NONE;
    case (q_cmd.kind)
      tte_pkg::CMD_RRQ: begin
        if (mode_r == MODE_IDLE) begin
          mode_nxt       = MODE_FETCH;
          next_block_nxt = tte_pkg::FIRST_BLOCK;
          retry_nxt      = 8'd0;
          wait_nxt       = '0;
          res_c[0]       = '{action: tte_pkg::ACT_DATA, blk: tte_pkg::FIRST_BLOCK,
                             err: tte_pkg::ERR_NONE, len: 16'd0};
          n_c            = 2'd1;
        end
      end
      tte_pkg::CMD_WRQ: begin
        if (mode_r == MODE_IDLE) begin
          mode_nxt       = MODE_WRITE;
          next_block_nxt = tte_pkg::FIRST_BLOCK;
          wait_nxt       = '0;
          res_c[0]       = RES_NONE;
          n_c            = 2'd1;
        end
      end
      tte_pkg::CMD_NOT_FOUND: begin
        if (mode_r == MODE_IDLE) begin
          res_c[0] = '{action: tte_pkg::ACT_ERROR, blk: 16'd0, err: tte_pkg::ERR_NOT_FOUND,
                       len: 16'd0};
          n_c      = 2'd1;
        end
      end
      tte_pkg::CMD_ILLEGAL: begin
        if (mode_r == MODE_IDLE) begin
          res_c[0] = '{action: tte_pkg::ACT_ERROR, blk: 16'd0, err: tte_pkg::ERR_ILLEGAL_OP,
                       len: 16'd0};
          n_c      = 2'd1;
        end
      end
      tte_pkg::CMD_DATA: begin
        if (mode_r == MODE_WRITE) begin
          // Current and past blocks are acknowledged; only the expected one is stored.
          if (q_cmd.blk <= next_block_r) begin
            res_c[0] = '{action: tte_pkg::ACT_ACK, blk: q_cmd.blk, err: tte_pkg::ERR_NONE,
                         len: 16'd0};
            n_c      = 2'd1;
          end
          if (q_cmd.blk == next_block_r) begin
            res_c[1]       = '{action: tte_pkg::ACT_STORE, blk: q_cmd.blk,
                               err: tte_pkg::ERR_NONE, len: q_cmd.len};
            n_c            = 2'd2;
            next_block_nxt = block_inc;
            wait_nxt       = '0;
            if (q_cmd.len != block_size_r) begin
              mode_nxt = MODE_IDLE;
              res_c[2] = '{action: tte_pkg::ACT_DONE, blk: 16'd0, err: tte_pkg::ERR_NONE,
                           len: 16'd0};
              n_c      = 2'd3;
            end
          end
        end
      end
      tte_pkg::CMD_ACK: begin
        if (mode_r == MODE_ACKWAIT) begin
          n_c = 2'd1;
          if (q_cmd.blk != next_block_r) begin
            res_c[0]  = fail_res;
            mode_nxt  = fail_mode;
            retry_nxt = fail_retry;
          end else if (short_r) begin
            mode_nxt = MODE_IDLE;
            res_c[0] = '{action: tte_pkg::ACT_DONE, blk: 16'd0, err: tte_pkg::ERR_NONE,
                         len: 16'd0};
          end else begin
            next_block_nxt = block_inc;
            retry_nxt      = 8'd0;
            if (block_inc == tte_pkg::LAST_BLOCK) begin
              // The block counter would run out: the read is aborted.
              mode_nxt = MODE_IDLE;
              res_c[0] = '{action: tte_pkg::ACT_ABORT, blk: 16'd0, err: tte_pkg::ERR_NONE,
                           len: 16'd0};
            end else begin
              mode_nxt = MODE_FETCH;
              res_c[0] = '{action: tte_pkg::ACT_DATA, blk: block_inc, err: tte_pkg::ERR_NONE,
                           len: 16'd0};
            end
          end
        end
      end
      tte_pkg::CMD_TICK: begin
        if (mode_r == MODE_WRITE) begin
          wait_nxt = wait_inc;
          if (32'(wait_inc) >= data_wait_r) begin
            mode_nxt = MODE_IDLE;
            res_c[0] = '{action: tte_pkg::ACT_ABORT, blk: 16'd0, err: tte_pkg::ERR_NONE,
                         len: 16'd0};
            n_c      = 2'd1;
          end
        end else if (mode_r == MODE_ACKWAIT) begin
          wait_nxt = wait_inc;
          if (32'(wait_inc) >= ack_wait_r) begin
            res_c[0]  = fail_res;
            mode_nxt  = fail_mode;
            retry_nxt = fail_retry;
            n_c       = 2'd1;
          end
        end
      end
      tte_pkg::CMD_LENGTH: begin
        if (mode_r == MODE_FETCH) begin
          short_nxt = (q_cmd.len < block_size_r);
          wait_nxt  = '0;
          mode_nxt  = MODE_ACKWAIT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= tte_pkg::BLOCK_SIZE_RST;
      ack_wait_r    <= tte_pkg::ACK_WAIT_RST;
      data_wait_r   <= tte_pkg::DATA_WAIT_RST;
      retry_limit_r <= tte_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        tte_pkg::CFG_BLOCK_SIZE:  block_size_r  <= cfg_wdata[15:0];
        tte_pkg::CFG_ACK_WAIT:    ack_wait_r    <= cfg_wdata[31:0];
        tte_pkg::CFG_DATA_WAIT:   data_wait_r   <= cfg_wdata[31:0];
        tte_pkg::CFG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      next_block_r <= tte_pkg::FIRST_BLOCK;
      retry_r      <= 8'd0;
      wait_r       <= '0;
      short_r      <= 1'b0;
      cnt_r        <= 2'd0;
    end else if (q_pop) begin
      mode_r       <= mode_nxt;
      next_block_r <= next_block_nxt;
      retry_r      <= retry_nxt;
      wait_r       <= wait_nxt;
      short_r      <= short_nxt;
      cnt_r        <= n_c;
    end else if (out_tvalid && out_tready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r[0] <= res_c[0];
      res_r[1] <= res_c[1];
      res_r[2] <= res_c[2];
    end else if (out_tvalid && out_tready) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tlast  = (cnt_r == 2'd1);
  assign out_tuser  = res_r[0].action;
  assign out_tdata  = {5'd0, res_r[0].len, res_r[0].err, res_r[0].blk};

endmodule

`default_nettype wire

[hdl/tte_checker.sv]
// Port-level checker for the TFTP transfer engine, bound to the top level.
// Depends on tte_pkg and tftp_transfer_engine.
`timescale 1ns / 1ps
`default_nettype none

module tte_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [tte_pkg::OUT_TUSER_W-1:0] out_tuser,
  input wire logic [tte_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tlast
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // An error code is present exactly on ERROR results.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == tte_pkg::ACT_ERROR) == (out_tdata[18:16] != 3'd0)))
    else $error("error code does not match action");

  // Only a store result carries a length.
  a_len_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != tte_pkg::ACT_STORE) |-> (out_tdata[34:19] == 16'd0))
    else $error("length on a result that is not a store");

  // Finished and aborted always close the run of results of an item.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == tte_pkg::ACT_DONE || out_tuser == tte_pkg::ACT_ABORT)
    |-> out_tlast)
    else $error("transfer end not marked last");

endmodule

bind tftp_transfer_engine tte_checker u_tte_checker (.*);

`default_nettype wire
